// File: rtl/cfsh_pkg.sv
// ----------------------------------------------------------------------------
// cfsh_pkg
// Shared types and constants for the case-folded string hash block.
// ----------------------------------------------------------------------------
package cfsh_pkg;

    localparam int CHAR_W    = 16;
    localparam int HASH_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int AVG_W     = 8;
    localparam int LOW_W     = 24;
    localparam int AVG_SHIFT = 3;
    localparam int MUL_SHIFT = 5;
    localparam int DIV_STEPS = HASH_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0] HASH_SEED   = 32'd5381;
    localparam logic [CHAR_W-1:0] LOWER_FIRST = 16'h0061;
    localparam logic [CHAR_W-1:0] LOWER_LAST  = 16'h007A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } cfsh_state_t;

    // controller -> datapath
    typedef struct packed {
        logic acc;      // fold one character into hash, sum and length
        logic start;    // load the divider from sum and length
        logic step;     // one restoring divide iteration
        logic finish;   // load result register, clear string state
    } cfsh_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_zero;
        logic count_gt1;
    } cfsh_stat_t;

endpackage

// File: rtl/cfsh_ctrl.sv
// ----------------------------------------------------------------------------
// cfsh_ctrl
// Sequencer: character accept, divide iterations, result hand-off.
// ----------------------------------------------------------------------------
module cfsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  cfsh_pkg::cfsh_stat_t stat,
    output cfsh_pkg::cfsh_cmd_t  cmd
);
    import cfsh_pkg::*;

    cfsh_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_cnt_reg, step_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (stat.is_zero)
                    begin
                        cmd.start     = 1'b1;
                        step_cnt_next = '0;
                        state_next    = stat.count_gt1 ? ST_DIV : ST_FIN;
                    end
                    else
                    begin
                        cmd.acc = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cfsh_dp.sv
// ----------------------------------------------------------------------------
// cfsh_dp
// Datapath: case fold, djb2 hash, sum and length, bit-serial divider,
// result register.
// ----------------------------------------------------------------------------
module cfsh_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cfsh_pkg::CHAR_W-1:0]   char_code,
    input  cfsh_pkg::cfsh_cmd_t           cmd,
    output cfsh_pkg::cfsh_stat_t          stat,
    output logic [cfsh_pkg::HASH_W-1:0]   hash_value
);
    import cfsh_pkg::*;

    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [HASH_W-1:0]  sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [HASH_W-1:0]  quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic [HASH_W-1:0]  out_reg, out_next;

    logic [CHAR_W-1:0]  folded;
    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   rem_diff;
    logic               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= HASH_SEED;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        if (char_code >= LOWER_FIRST && char_code <= LOWER_LAST)
            folded = char_code - CASE_OFFSET;
        else
            folded = char_code;
    end

    // restoring divide: rem stays below the 16-bit divisor
    assign rem_sh   = {rem_reg, quo_reg[HASH_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign fits     = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        hash_next  = hash_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        out_next   = out_reg;
        if (cmd.acc)
        begin
            hash_next  = ((hash_reg << MUL_SHIFT) + hash_reg)
                         ^ {{(HASH_W-CHAR_W){1'b0}}, folded};
            sum_next   = sum_reg + {{(HASH_W-CHAR_W){1'b0}}, folded};
            count_next = count_reg + 1'b1;
        end
        if (cmd.start)
        begin
            // quotient register doubles as the average when no divide runs
            quo_next = sum_reg;
            rem_next = '0;
            div_next = count_reg;
        end
        if (cmd.step)
        begin
            quo_next = {quo_reg[HASH_W-2:0], fits};
            rem_next = fits ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
        if (cmd.finish)
        begin
            out_next   = {quo_reg[AVG_SHIFT +: AVG_W], hash_reg[LOW_W-1:0]};
            hash_next  = HASH_SEED;
            sum_next   = '0;
            count_next = '0;
        end
    end

    assign stat.is_zero   = (char_code == '0);
    assign stat.count_gt1 = (count_reg > COUNT_W'(1));
    assign hash_value     = out_reg;

endmodule

// File: rtl/case_folded_string_hash32.sv
// ----------------------------------------------------------------------------
// case_folded_string_hash32
// Case-folded djb2-style (xor variant) string hash: low 24 hash bits, bits [10:3] of the average character on top.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | char_code  [15:0]
//  output   | out_valid / out_stall| hash_value [31:0]
//
//  A non-zero character is accepted while idle; characters stream back to back.
//  A zero character ends the string: when the length is 0 or 1 the divide is skipped,
//  else the one-bit-per-cycle 32-step divider runs before the result is loaded.
//  Input is stalled during the divide and while the result register is full
//  at the end of a string; characters keep flowing while a result waits.
//  Reset clears the string state to an empty string (hash 5381).
// ----------------------------------------------------------------------------
module case_folded_string_hash32 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cfsh_pkg::CHAR_W-1:0] char_code,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cfsh_pkg::HASH_W-1:0] hash_value
);
    import cfsh_pkg::*;

    cfsh_cmd_t  cmd;
    cfsh_stat_t stat;

    cfsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cfsh_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .cmd        (cmd),
        .stat       (stat),
        .hash_value (hash_value)
    );

endmodule

// File: rtl/cfsh_chk.sv
// ----------------------------------------------------------------------------
// cfsh_chk
// Port-level checks for the string hash block, bound to the top level.
// ----------------------------------------------------------------------------
module cfsh_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [cfsh_pkg::CHAR_W-1:0] char_code,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [cfsh_pkg::HASH_W-1:0] hash_value
);
    import cfsh_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_value))
        else $error("result changed while stalled");

    // end of string always stalls the input in the cycle after it is accepted
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (char_code == '0) |=> in_stall)
        else $error("request taken right after end of string");

    // a new result only appears out of the end-of-string sequence
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared outside end-of-string handling");

endmodule

bind case_folded_string_hash32 cfsh_chk u_cfsh_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
);
